// ----- hw/rtl/packet_reorder_buffer_defines.svh -----
// assertion macros for the packet reorder buffer checker
// expects signals named clk and rst in the scope of each use
`ifndef PACKET_REORDER_BUFFER_DEFINES_SVH
`define PACKET_REORDER_BUFFER_DEFINES_SVH

// same-cycle implication, off while rst is high
`define PRB_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while rst is high
`define PRB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/prb_pkg.sv -----
// packet reorder buffer: shared types and constants
// used by the controller, the datapath and the top level
package prb_pkg;

  // configuration port
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 8;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DISCARD_MODE = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SKIP_GAP     = 1'b1;

  // skip gap register
  localparam int SKIP_GAP_BITS = 8;
  localparam logic [SKIP_GAP_BITS-1:0] SKIP_GAP_RESET = 8'd4;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_READ,
    ST_CHECK,
    ST_FINISH
  } prb_state_t;

  typedef enum logic [1:0] {
    EXP_KEEP,
    EXP_INC,
    EXP_SEQ1
  } exp_op_t;

  // controller to datapath
  typedef struct packed {
    logic    clr_wr;
    logic    take_pkt;
    logic    look;
    exp_op_t exp_op;
    logic    skp_val;
    logic    direct_emit;
    logic    direct_clr;
    logic    store_wr;
    logic    rd_exp;
    logic    rel_step;
    logic    flush;
    logic    pend_wr;
    logic    pend_val;
  } prb_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic newer;
    logic in_order;
    logic force_skip;
    logic pkt_ok;
    logic discard;
    logic pending;
    logic slot_full;
    logic budget_left;
    logic hold_valid;
    logic out_free;
    logic clear_done;
  } prb_status_t;

endpackage

// ----- hw/rtl/prb_if.sv -----
// packet reorder buffer channel interfaces: arrived packets and results
// valid/ready handshake, payload widths set by parameters
interface prb_pkt_if #(
  parameter int SEQ_BITS = 8,
  parameter int TAG_BITS = 16
) ();
  logic                valid;
  logic                ready;
  logic [SEQ_BITS-1:0] seq_num;
  logic [TAG_BITS-1:0] payload_tag;
  logic                payload_ok;
  logic                buffer_low;

  modport source (output valid, output seq_num, output payload_tag, output payload_ok,
                  output buffer_low, input ready);
  modport sink (input valid, input seq_num, input payload_tag, input payload_ok,
                input buffer_low, output ready);
endinterface

interface prb_res_if #(
  parameter int SEQ_BITS = 8,
  parameter int TAG_BITS = 16
) ();
  logic                valid;
  logic                ready;
  logic [SEQ_BITS-1:0] out_seq;
  logic [TAG_BITS-1:0] out_tag;
  logic                from_store;
  logic                clear_low;
  logic                skipped;
  logic [SEQ_BITS-1:0] expected_after;
  logic                last;

  modport source (output valid, output out_seq, output out_tag, output from_store,
                  output clear_low, output skipped, output expected_after, output last,
                  input ready);
  modport sink (input valid, input out_seq, input out_tag, input from_store,
                input clear_low, input skipped, input expected_after, input last,
                output ready);
endinterface

// ----- hw/rtl/prb_ctrl.sv -----
// packet reorder buffer controller: sequences clear pass, packet decision and release walk
// depends on prb_pkg for state, command and status types
module prb_ctrl import prb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  prb_status_t status,
  output prb_cmd_t    cmd
);

  prb_state_t state;
  prb_state_t state_next;
  logic       walk;
  logic       hold_free;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign hold_free = !status.hold_valid || status.out_free;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.exp_op = EXP_KEEP;
    in_ready   = 1'b0;
    walk       = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (status.clear_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take_pkt = 1'b1;
          state_next   = ST_LOOK;
        end
      end
      ST_LOOK: begin
        cmd.look = 1'b1;
        walk     = status.pending;
        if (status.discard) begin
          // every newer packet with payload_ok goes out, expected jumps past it
          if (status.newer) begin
            cmd.skp_val     = !status.in_order;
            cmd.exp_op      = EXP_SEQ1;
            cmd.direct_emit = status.pkt_ok;
          end
        end else if (status.newer) begin
          walk = 1'b1;
          if (status.in_order) begin
            if (status.pkt_ok && !status.slot_full) begin
              cmd.exp_op      = EXP_INC;
              cmd.direct_emit = 1'b1;
              cmd.direct_clr  = 1'b1;
            end
          end else begin
            // early packet: maybe skip the expected one, hold this one if ok and its slot is free
            if (status.force_skip) begin
              cmd.skp_val = 1'b1;
              cmd.exp_op  = EXP_INC;
            end
            cmd.store_wr = !status.slot_full && status.pkt_ok;
          end
        end
        if (walk) begin
          state_next = ST_READ;
        end else begin
          cmd.pend_wr  = 1'b1;
          cmd.pend_val = 1'b0;
          state_next   = ST_FINISH;
        end
      end
      ST_READ: begin
        cmd.rd_exp = 1'b1;
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        // one held packet per cycle while the run lasts and the result staging is free
        if (status.slot_full && status.budget_left) begin
          if (hold_free) begin
            cmd.rel_step = 1'b1;
          end
        end else begin
          cmd.pend_wr  = 1'b1;
          cmd.pend_val = status.slot_full;
          state_next   = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!status.hold_valid) begin
          state_next = ST_IDLE;
        end else if (status.out_free) begin
          cmd.flush  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

// ----- hw/rtl/prb_datapath.sv -----
// packet reorder buffer datapath: slot memory, expected number, result staging
// depends on prb_pkg; driven by prb_ctrl commands
module prb_datapath import prb_pkg::*; #(
  parameter int SEQ_BITS = 8,
  parameter int TAG_BITS = 16,
  parameter int MAX_RUN  = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [SEQ_BITS-1:0]      in_seq,
  input  logic [TAG_BITS-1:0]      in_tag,
  input  logic                     in_ok,
  input  logic                     in_low,
  input  logic                     cfg_wr_en,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  prb_cmd_t                 cmd,
  output prb_status_t              status,
  output logic                     res_valid,
  input  logic                     res_ready,
  output logic [SEQ_BITS-1:0]      res_seq,
  output logic [TAG_BITS-1:0]      res_tag,
  output logic                     res_from_store,
  output logic                     res_clear_low,
  output logic                     res_skipped,
  output logic [SEQ_BITS-1:0]      res_expected_after,
  output logic                     res_last
);

  localparam int SLOTS    = 1 << SEQ_BITS;
  localparam int CNT_BITS = $clog2(MAX_RUN + 1);
  localparam int CMP_BITS = (SEQ_BITS > SKIP_GAP_BITS) ? SEQ_BITS : SKIP_GAP_BITS;

  // configuration
  logic                     discard_mode;
  logic [SKIP_GAP_BITS-1:0] skip_gap;

  // sequencing state
  logic [SEQ_BITS-1:0] expected;
  logic                pending;
  logic                skp;
  logic [CNT_BITS-1:0] run_cnt;
  logic [SEQ_BITS-1:0] clr_cnt;

  // current packet
  logic [SEQ_BITS-1:0] cur_seq;
  logic [TAG_BITS-1:0] cur_tag;
  logic                cur_ok;
  logic                cur_low;

  // slot memory: full bit over handle
  logic [TAG_BITS:0]   slot_mem [SLOTS];
  logic                rd_full;
  logic [TAG_BITS-1:0] rd_tag;
  logic                mem_we;
  logic                mem_re;
  logic [SEQ_BITS-1:0] mem_waddr;
  logic [SEQ_BITS-1:0] mem_raddr;
  logic [TAG_BITS:0]   mem_wdata;

  // staged result waiting to learn whether it is the last
  logic                hold_valid;
  logic [SEQ_BITS-1:0] hold_seq;
  logic [TAG_BITS-1:0] hold_tag;
  logic                hold_from_store;
  logic                hold_clr;
  logic                hold_skp;
  logic [SEQ_BITS-1:0] hold_exp;

  logic [SEQ_BITS-1:0] fwd_span;
  logic [SEQ_BITS-1:0] lead;
  logic [SEQ_BITS-1:0] exp_inc;
  logic [SEQ_BITS-1:0] seq_inc;
  logic                out_free;
  logic                push;

  // serial arithmetic on the sequence ring
  assign fwd_span = cur_seq - expected + SEQ_BITS'(1);
  assign lead     = cur_seq - expected;
  assign exp_inc  = expected + SEQ_BITS'(1);
  assign seq_inc  = cur_seq + SEQ_BITS'(1);

  assign out_free = !res_valid || res_ready;
  assign push     = cmd.flush || (cmd.rel_step && hold_valid);

  // status to controller
  always_comb begin
    status.newer       = (fwd_span != '0) && !fwd_span[SEQ_BITS-1];
    status.in_order    = (cur_seq == expected);
    status.force_skip  = (CMP_BITS'(lead) >= CMP_BITS'(skip_gap)) || cur_low;
    status.pkt_ok      = cur_ok;
    status.discard     = discard_mode;
    status.pending     = pending;
    status.slot_full   = rd_full;
    status.budget_left = (run_cnt < CNT_BITS'(MAX_RUN));
    status.hold_valid  = hold_valid;
    status.out_free    = out_free;
    status.clear_done  = &clr_cnt;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      discard_mode <= 1'b0;
      skip_gap     <= SKIP_GAP_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_DISCARD_MODE: discard_mode <= cfg_data[0];
        CFG_SKIP_GAP:     skip_gap <= cfg_data[SKIP_GAP_BITS-1:0];
        default: ;
      endcase
    end
  end

  // memory port selection
  always_comb begin
    mem_we    = cmd.clr_wr || cmd.store_wr || cmd.rel_step;
    mem_re    = cmd.take_pkt || cmd.rd_exp || cmd.rel_step;
    mem_wdata = cmd.store_wr ? {1'b1, cur_tag} : {1'b0, rd_tag};
    if (cmd.clr_wr) begin
      mem_waddr = clr_cnt;
    end else if (cmd.store_wr) begin
      mem_waddr = cur_seq;
    end else begin
      mem_waddr = expected;
    end
    if (cmd.take_pkt) begin
      mem_raddr = in_seq;
    end else if (cmd.rd_exp) begin
      mem_raddr = expected;
    end else begin
      mem_raddr = exp_inc;
    end
  end

  // slot memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      {rd_full, rd_tag} <= slot_mem[mem_raddr];
    end
  end

  // clearing pass counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_wr) begin
      clr_cnt <= clr_cnt + SEQ_BITS'(1);
    end
  end

  // current packet latch
  always_ff @(posedge clk) begin
    if (cmd.take_pkt) begin
      cur_seq <= in_seq;
      cur_tag <= in_tag;
      cur_ok  <= in_ok;
      cur_low <= in_low;
    end
  end

  // expected number, skip flag, pending flag, run budget
  always_ff @(posedge clk) begin
    if (rst) begin
      expected <= '0;
      pending  <= 1'b0;
      skp      <= 1'b0;
      run_cnt  <= '0;
    end else begin
      if (cmd.rel_step) begin
        expected <= exp_inc;
      end else begin
        case (cmd.exp_op)
          EXP_INC:  expected <= exp_inc;
          EXP_SEQ1: expected <= seq_inc;
          default:  expected <= expected;
        endcase
      end
      if (cmd.look) begin
        skp <= cmd.skp_val;
      end
      if (cmd.pend_wr) begin
        pending <= cmd.pend_val;
      end
      if (cmd.take_pkt) begin
        run_cnt <= '0;
      end else if (cmd.direct_emit || cmd.rel_step) begin
        run_cnt <= run_cnt + CNT_BITS'(1);
      end
    end
  end

  // result staging
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (cmd.direct_emit || cmd.rel_step) begin
      hold_valid <= 1'b1;
    end else if (cmd.flush) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.direct_emit) begin
      hold_seq        <= cur_seq;
      hold_tag        <= cur_tag;
      hold_from_store <= 1'b0;
      hold_clr        <= cmd.direct_clr;
      hold_skp        <= cmd.skp_val;
      hold_exp        <= seq_inc;
    end else if (cmd.rel_step) begin
      hold_seq        <= expected;
      hold_tag        <= rd_tag;
      hold_from_store <= 1'b1;
      hold_clr        <= 1'b0;
      hold_skp        <= skp;
      hold_exp        <= exp_inc;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (push) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      res_seq            <= hold_seq;
      res_tag            <= hold_tag;
      res_from_store     <= hold_from_store;
      res_clear_low      <= hold_clr;
      res_skipped        <= hold_skp;
      res_expected_after <= hold_exp;
      res_last           <= cmd.flush;
    end
  end

endmodule

// ----- hw/rtl/packet_reorder_buffer.sv -----
// packet reorder buffer top level: controller plus datapath
// depends on prb_pkg, prb_if, prb_ctrl and prb_datapath
//
// Usage
//   pkt carries one arrived packet per beat (seq_num, payload_tag, payload_ok,
//   buffer_low); res carries the in-order deliveries, one beat per packet, with
//   last set on the final beat caused by a packet. A packet causing no delivery
//   gives no beat. cfg_wr_en/cfg_index/cfg_data write discard_mode (index 0) and
//   skip_gap (index 1); the user writes only while idle, unchecked by the block.
// Timing
//   one packet at a time: pkt.ready is high only while the block waits for a
//   packet. A packet with no release walk goes from accept through the look and
//   finish states back to idle; one that walks also passes the read and check
//   states, releasing held packets one by one through the memory's single read
//   port. Beats go via staging and output registers; at most MAX_RUN per packet.
// Reset
//   rst clears the expected number to zero and the configuration to its defaults,
//   then a clearing pass empties all 2^SEQ_BITS slots (256 at the default width)
//   of the slot memory; pkt.ready stays low during the pass.
// Stall
//   a beat waits in the output register while res.ready is low; the walk then
//   stops in place and resumes when the beat is taken.
module packet_reorder_buffer import prb_pkg::*; #(
  parameter int SEQ_BITS = 8,
  parameter int TAG_BITS = 16,
  parameter int MAX_RUN  = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  prb_pkt_if.sink                  pkt,
  prb_res_if.source                res,
  input  logic                     cfg_wr_en,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  prb_cmd_t    cmd;
  prb_status_t status;

  // control
  prb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pkt.valid),
    .in_ready (pkt.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath
  prb_datapath #(
    .SEQ_BITS (SEQ_BITS),
    .TAG_BITS (TAG_BITS),
    .MAX_RUN  (MAX_RUN)
  ) u_datapath (
    .clk                (clk),
    .rst                (rst),
    .in_seq             (pkt.seq_num),
    .in_tag             (pkt.payload_tag),
    .in_ok              (pkt.payload_ok),
    .in_low             (pkt.buffer_low),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .cmd                (cmd),
    .status             (status),
    .res_valid          (res.valid),
    .res_ready          (res.ready),
    .res_seq            (res.out_seq),
    .res_tag            (res.out_tag),
    .res_from_store     (res.from_store),
    .res_clear_low      (res.clear_low),
    .res_skipped        (res.skipped),
    .res_expected_after (res.expected_after),
    .res_last           (res.last)
  );

endmodule

// ----- hw/rtl/prb_checker.sv -----
// packet reorder buffer port checker and its bind to the top level
// depends on packet_reorder_buffer_defines.svh for the assertion macros
`include "packet_reorder_buffer_defines.svh"

module prb_checker #(
  parameter int SEQ_BITS = 8,
  parameter int TAG_BITS = 16
) (
  input logic                clk,
  input logic                rst,
  input logic                pkt_ready,
  input logic                res_valid,
  input logic                res_ready,
  input logic [SEQ_BITS-1:0] res_seq,
  input logic [TAG_BITS-1:0] res_tag,
  input logic                res_from_store,
  input logic                res_clear_low,
  input logic                res_skipped,
  input logic [SEQ_BITS-1:0] res_expected_after,
  input logic                res_last
);

  // a stalled beat holds
  `PRB_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable({res_seq, res_tag, res_from_store, res_clear_low, res_skipped, res_expected_after, res_last}), "stalled result beat changed")

  // expected number always moves just past the delivered packet
  `PRB_ASSERT_SAME(a_exp_after, res_valid, res_expected_after == SEQ_BITS'(res_seq + 1'b1), "expected_after is not out_seq plus one")

  // clear_low only on a direct in-order delivery
  `PRB_ASSERT_SAME(a_clear_low, res_valid && res_clear_low, !res_from_store && !res_skipped, "clear_low on a released or skipping beat")

  // no packet taken right after reset: the slot clearing pass runs first
  `PRB_ASSERT_SAME(a_clear_pass, $past(rst), !pkt_ready, "packet ready during slot clearing")

endmodule

bind packet_reorder_buffer prb_checker #(
  .SEQ_BITS (SEQ_BITS),
  .TAG_BITS (TAG_BITS)
) u_prb_checker (
  .clk                (clk),
  .rst                (rst),
  .pkt_ready          (pkt.ready),
  .res_valid          (res.valid),
  .res_ready          (res.ready),
  .res_seq            (res.out_seq),
  .res_tag            (res.out_tag),
  .res_from_store     (res.from_store),
  .res_clear_low      (res.clear_low),
  .res_skipped        (res.skipped),
  .res_expected_after (res.expected_after),
  .res_last           (res.last)
);
